// ===== rtl/rme_pkg.sv =====
package rme_pkg;

   localparam int DATA_W = 36;
   localparam int ANG_W = 34;
   localparam int STAGES_DEFAULT = 16;
   localparam int TAB_LEN = 24;
   localparam int MAG_W = 35;
   localparam int MAG_LO_W = 18;
   localparam int GAIN_W = 30;

   localparam logic [GAIN_W-1:0] INV_GAIN = 30'd652032874;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic signed [ANG_W-1:0]  ang_type;
   typedef logic signed [15:0]       bam_type;

   localparam ang_type ANG_PI = 34'sd2147483648;

   // atan(2^-i), 2^31 units per pi
   function automatic ang_type atan_entry(input int i);
      ang_type t;
      case (i)
         0:  t = 34'sd536870912;
         1:  t = 34'sd316933405;
         2:  t = 34'sd167458907;
         3:  t = 34'sd85004756;
         4:  t = 34'sd42667331;
         5:  t = 34'sd21354465;
         6:  t = 34'sd10679838;
         7:  t = 34'sd5340245;
         8:  t = 34'sd2670163;
         9:  t = 34'sd1335086;
         10: t = 34'sd667544;
         11: t = 34'sd333772;
         12: t = 34'sd166886;
         13: t = 34'sd83443;
         14: t = 34'sd41721;
         15: t = 34'sd20860;
         16: t = 34'sd10430;
         17: t = 34'sd5215;
         18: t = 34'sd2607;
         19: t = 34'sd1303;
         20: t = 34'sd651;
         21: t = 34'sd325;
         22: t = 34'sd162;
         23: t = 34'sd81;
         default: t = '0;
      endcase
      return t;
   endfunction

   // Q2.14 entry into internal Q.30
   function automatic data_type widen(input bam_type v);
      return {{(DATA_W-32){v[15]}}, v, 16'b0};
   endfunction

   // round to nearest binary angle, wrap to 16 bits
   function automatic bam_type to_bam(input ang_type z);
      ang_type t;
      t = z + 34'sd32768;
      return t[31:16];
   endfunction

endpackage

// ===== rtl/rme_yaw_cordic.sv =====
module rme_yaw_cordic #(
   parameter int N = rme_pkg::STAGES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_vld,
   input  rme_pkg::data_type in_x,
   input  rme_pkg::data_type in_y,
   input  rme_pkg::data_type in_ax0,
   input  rme_pkg::data_type in_ay0,
   input  rme_pkg::data_type in_ax1,
   input  rme_pkg::data_type in_ay1,
   input  rme_pkg::bam_type  in_r20,
   output logic              out_vld,
   output rme_pkg::data_type out_mag,
   output rme_pkg::data_type out_ay0,
   output rme_pkg::data_type out_ay1,
   output rme_pkg::ang_type  out_yaw,
   output rme_pkg::bam_type  out_r20
);
   import rme_pkg::*;

   logic     vld_ff [0:N];
   logic     zf_ff  [0:N];
   data_type x_ff   [0:N];
   data_type y_ff   [0:N];
   data_type ax0_ff [0:N];
   data_type ay0_ff [0:N];
   data_type ax1_ff [0:N];
   data_type ay1_ff [0:N];
   ang_type  z_ff   [0:N];
   bam_type  r20_ff [0:N];

   logic neg, zero;

   always_comb begin
      zero = (in_x == '0) && (in_y == '0);
      neg  = in_x[DATA_W-1];
   end

   // prep: fold into right half plane, slaved vectors follow
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zf_ff[0]  <= zero;
         x_ff[0]   <= neg ? -in_x : in_x;
         y_ff[0]   <= neg ? -in_y : in_y;
         ax0_ff[0] <= neg ? -in_ax0 : in_ax0;
         ay0_ff[0] <= neg ? -in_ay0 : in_ay0;
         ax1_ff[0] <= neg ? -in_ax1 : in_ax1;
         ay1_ff[0] <= neg ? -in_ay1 : in_ay1;
         z_ff[0]   <= neg ? ANG_PI : '0;
         r20_ff[0] <= in_r20;
      end
   end

   for (genvar k = 1; k <= N; k++) begin : g_stage
      localparam int S = k - 1;
      logic     cw;
      data_type x_in, y_in, ax0_in, ay0_in, ax1_in, ay1_in;
      ang_type  z_in;

      always_comb begin
         cw     = !y_ff[k-1][DATA_W-1];
         x_in   = x_ff[k-1];
         y_in   = y_ff[k-1];
         ax0_in = ax0_ff[k-1];
         ay0_in = ay0_ff[k-1];
         ax1_in = ax1_ff[k-1];
         ay1_in = ay1_ff[k-1];
         z_in   = z_ff[k-1];
         // both arguments zero: no rotation at all
         if (!zf_ff[k-1]) begin
            if (cw) begin
               x_in   = x_ff[k-1] + (y_ff[k-1] >>> S);
               y_in   = y_ff[k-1] - (x_ff[k-1] >>> S);
               z_in   = z_ff[k-1] + atan_entry(S);
               ax0_in = ax0_ff[k-1] + (ay0_ff[k-1] >>> S);
               ay0_in = ay0_ff[k-1] - (ax0_ff[k-1] >>> S);
               ax1_in = ax1_ff[k-1] + (ay1_ff[k-1] >>> S);
               ay1_in = ay1_ff[k-1] - (ax1_ff[k-1] >>> S);
            end else begin
               x_in   = x_ff[k-1] - (y_ff[k-1] >>> S);
               y_in   = y_ff[k-1] + (x_ff[k-1] >>> S);
               z_in   = z_ff[k-1] - atan_entry(S);
               ax0_in = ax0_ff[k-1] - (ay0_ff[k-1] >>> S);
               ay0_in = ay0_ff[k-1] + (ax0_ff[k-1] >>> S);
               ax1_in = ax1_ff[k-1] - (ay1_ff[k-1] >>> S);
               ay1_in = ay1_ff[k-1] + (ax1_ff[k-1] >>> S);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            zf_ff[k]  <= zf_ff[k-1];
            x_ff[k]   <= x_in;
            y_ff[k]   <= y_in;
            ax0_ff[k] <= ax0_in;
            ay0_ff[k] <= ay0_in;
            ax1_ff[k] <= ax1_in;
            ay1_ff[k] <= ay1_in;
            z_ff[k]   <= z_in;
            r20_ff[k] <= r20_ff[k-1];
         end
      end
   end

   assign out_vld = vld_ff[N];
   assign out_mag = x_ff[N];
   assign out_ay0 = ay0_ff[N];
   assign out_ay1 = ay1_ff[N];
   assign out_yaw = z_ff[N];
   assign out_r20 = r20_ff[N];

   // x starts in the right half plane and only grows
   assert property (@(posedge clock) disable iff (reset)
      vld_ff[N] |-> !x_ff[N][DATA_W-1])
      else $error("yaw magnitude negative");

endmodule

// ===== rtl/rme_gain.sv =====
module rme_gain (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_vld,
   input  rme_pkg::data_type in_mag,
   input  rme_pkg::data_type in_ay0,
   input  rme_pkg::data_type in_ay1,
   input  rme_pkg::ang_type  in_yaw,
   input  rme_pkg::bam_type  in_r20,
   output logic              out_vld,
   output rme_pkg::data_type out_px,
   output rme_pkg::data_type out_ay0,
   output rme_pkg::data_type out_ay1,
   output rme_pkg::ang_type  out_yaw,
   output rme_pkg::bam_type  out_r20
);
   import rme_pkg::*;

   localparam int HI_W = MAG_W - MAG_LO_W;
   localparam int PLO_W = MAG_LO_W + GAIN_W;
   localparam int PHI_W = HI_W + GAIN_W;
   localparam int SUM_W = PHI_W + MAG_LO_W + 1;

   logic [1:0]       vld_ff;
   logic [PLO_W-1:0] plo_ff, plo_in;
   logic [PHI_W-1:0] phi_ff, phi_in;
   data_type         ay0_ff [0:1];
   data_type         ay1_ff [0:1];
   ang_type          yaw_ff [0:1];
   bam_type          r20_ff [0:1];
   data_type         px_ff, px_in;
   logic [SUM_W-1:0] sum;

   // magnitude is non-negative: split into two narrow products
   always_comb begin
      plo_in = PLO_W'(in_mag[MAG_LO_W-1:0]) * PLO_W'(INV_GAIN);
      phi_in = PHI_W'(in_mag[MAG_W-1:MAG_LO_W]) * PHI_W'(INV_GAIN);
      sum    = {1'b0, phi_ff, {MAG_LO_W{1'b0}}} + SUM_W'(plo_ff);
      px_in  = $signed(sum[GAIN_W +: DATA_W]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         plo_ff    <= plo_in;
         phi_ff    <= phi_in;
         px_ff     <= px_in;
         ay0_ff[0] <= in_ay0;
         ay1_ff[0] <= in_ay1;
         yaw_ff[0] <= in_yaw;
         r20_ff[0] <= in_r20;
         ay0_ff[1] <= ay0_ff[0];
         ay1_ff[1] <= ay1_ff[0];
         yaw_ff[1] <= yaw_ff[0];
         r20_ff[1] <= r20_ff[0];
      end
   end

   assign out_vld = vld_ff[1];
   assign out_px  = px_ff;
   assign out_ay0 = ay0_ff[1];
   assign out_ay1 = ay1_ff[1];
   assign out_yaw = yaw_ff[1];
   assign out_r20 = r20_ff[1];

endmodule

// ===== rtl/rme_atan_cordic.sv =====
module rme_atan_cordic #(
   parameter int N = rme_pkg::STAGES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_vld,
   input  rme_pkg::data_type in_x [2],
   input  rme_pkg::data_type in_y [2],
   input  rme_pkg::ang_type  in_yaw,
   output logic              out_vld,
   output rme_pkg::ang_type  out_z [2],
   output rme_pkg::ang_type  out_yaw
);
   import rme_pkg::*;

   logic    vld_ff [0:N];
   ang_type yaw_ff [0:N];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         yaw_ff[0] <= in_yaw;
      end
   end

   for (genvar k = 1; k <= N; k++) begin : g_ctl
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            yaw_ff[k] <= yaw_ff[k-1];
         end
      end
   end

   // lane 0 pitch, lane 1 roll
   for (genvar ln = 0; ln < 2; ln++) begin : g_lane
      logic     zf_ff [0:N];
      data_type x_ff  [0:N];
      data_type y_ff  [0:N];
      ang_type  z_ff  [0:N];
      logic     neg, zero;

      always_comb begin
         zero = (in_x[ln] == '0) && (in_y[ln] == '0);
         neg  = in_x[ln][DATA_W-1];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            zf_ff[0] <= zero;
            x_ff[0]  <= neg ? -in_x[ln] : in_x[ln];
            y_ff[0]  <= neg ? -in_y[ln] : in_y[ln];
            z_ff[0]  <= neg ? ANG_PI : '0;
         end
      end

      for (genvar k = 1; k <= N; k++) begin : g_stage
         localparam int S = k - 1;
         data_type x_in, y_in;
         ang_type  z_in;

         always_comb begin
            x_in = x_ff[k-1];
            y_in = y_ff[k-1];
            z_in = z_ff[k-1];
            if (!zf_ff[k-1]) begin
               if (!y_ff[k-1][DATA_W-1]) begin
                  x_in = x_ff[k-1] + (y_ff[k-1] >>> S);
                  y_in = y_ff[k-1] - (x_ff[k-1] >>> S);
                  z_in = z_ff[k-1] + atan_entry(S);
               end else begin
                  x_in = x_ff[k-1] - (y_ff[k-1] >>> S);
                  y_in = y_ff[k-1] + (x_ff[k-1] >>> S);
                  z_in = z_ff[k-1] - atan_entry(S);
               end
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               zf_ff[k] <= zf_ff[k-1];
               x_ff[k]  <= x_in;
               y_ff[k]  <= y_in;
               z_ff[k]  <= z_in;
            end
         end
      end

      assign out_z[ln] = z_ff[N];

      assert property (@(posedge clock) disable iff (reset)
         vld_ff[N] |-> !x_ff[N][DATA_W-1])
         else $error("atan lane magnitude negative");
   end

   assign out_vld = vld_ff[N];
   assign out_yaw = yaw_ff[N];

endmodule

// ===== rtl/rotation_matrix_to_euler.sv =====
// Throughput: one matrix per cycle while rsp is not stalled; two CORDIC pipelines of
// CORDIC_STAGES stages in series, with a two-stage split gain multiply between them.
// Backpressure on rsp freezes the whole pipeline; nothing is dropped or repeated.
// Reset (synchronous, active high) clears all valid bits; data registers are not reset.
module rotation_matrix_to_euler #(
   parameter int CORDIC_STAGES = rme_pkg::STAGES_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [111:0] req_tdata,  // r00, r01, r02, r10, r11, r12, r20 (16 bits each)
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [47:0]  rsp_tdata   // yaw_angle, pitch_angle, roll_angle (16 bits each)
);
   import rme_pkg::*;

   logic     en;
   logic     yaw_vld, gain_vld, atan_vld;
   data_type yaw_mag, yaw_ay0, yaw_ay1;
   ang_type  yaw_z;
   bam_type  yaw_r20;
   data_type g_px, g_ay0, g_ay1;
   ang_type  g_yaw;
   bam_type  g_r20;
   data_type at_x [2];
   data_type at_y [2];
   ang_type  at_z [2];
   ang_type  at_yaw;
   logic        rsp_vld_ff;
   logic [47:0] rsp_data_ff;

   assign en         = !rsp_vld_ff || rsp_tready;
   assign req_tready = en;

   rme_yaw_cordic #(.N(CORDIC_STAGES)) u_yaw (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (req_tvalid),
      .in_x    (widen(req_tdata[15:0])),
      .in_y    (widen(req_tdata[63:48])),
      .in_ax0  (widen(req_tdata[31:16])),
      .in_ay0  (widen(req_tdata[79:64])),
      .in_ax1  (widen(req_tdata[47:32])),
      .in_ay1  (widen(req_tdata[95:80])),
      .in_r20  (req_tdata[111:96]),
      .out_vld (yaw_vld),
      .out_mag (yaw_mag),
      .out_ay0 (yaw_ay0),
      .out_ay1 (yaw_ay1),
      .out_yaw (yaw_z),
      .out_r20 (yaw_r20)
   );

   rme_gain u_gain (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (yaw_vld),
      .in_mag  (yaw_mag),
      .in_ay0  (yaw_ay0),
      .in_ay1  (yaw_ay1),
      .in_yaw  (yaw_z),
      .in_r20  (yaw_r20),
      .out_vld (gain_vld),
      .out_px  (g_px),
      .out_ay0 (g_ay0),
      .out_ay1 (g_ay1),
      .out_yaw (g_yaw),
      .out_r20 (g_r20)
   );

   // pitch = atan2(-r20, px), roll = atan2(-ay1, ay0)
   always_comb begin
      at_x[0] = g_px;
      at_y[0] = -widen(g_r20);
      at_x[1] = g_ay0;
      at_y[1] = -g_ay1;
   end

   rme_atan_cordic #(.N(CORDIC_STAGES)) u_atan (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (gain_vld),
      .in_x    (at_x),
      .in_y    (at_y),
      .in_yaw  (g_yaw),
      .out_vld (atan_vld),
      .out_z   (at_z),
      .out_yaw (at_yaw)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         rsp_vld_ff <= atan_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= {to_bam(at_z[1]), to_bam(at_z[0]), to_bam(at_yaw)};
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("input stalled without output backpressure");

endmodule
